[hw/rtl/chunk_deframer_crc_check_defines.svh]
// Assertion macros for the checker of the chunk deframer.
`ifndef CHUNK_DEFRAMER_CRC_CHECK_DEFINES_SVH
`define CHUNK_DEFRAMER_CRC_CHECK_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CDCC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CDCC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/cdcc_pkg.sv]
// Package with types, constants and the CRC-32C byte function of the chunk deframer.
package cdcc_pkg;

    localparam int MAX_CHUNK_BYTES = 65536;
    localparam int HEADER_BYTES    = 16;
    localparam int POS_W           = $clog2(HEADER_BYTES);
    localparam int LEFT_W          = $clog2(MAX_CHUNK_BYTES + 1);

    // Header byte offsets.
    localparam logic [POS_W-1:0] POS_LEN   = POS_W'(4);
    localparam logic [POS_W-1:0] POS_CRC   = POS_W'(8);
    localparam logic [POS_W-1:0] POS_FLAGS = POS_W'(12);
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(HEADER_BYTES - 1);

    localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Summary status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_TRUNC = 2'd1;
    localparam logic [1:0] ST_RSVD  = 2'd2;
    localparam logic [1:0] ST_LONG  = 2'd3;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Result queue geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [31:0] frame_seq;
        logic [31:0] payload_len;
        logic [7:0]  chunk_flags;
        logic [1:0]  status;
        logic        crc_match;
    } t_result;

    // Up to two results per input item; slot one is used only with slot zero.
    typedef struct packed {
        logic    vld0;
        logic    vld1;
        t_result res0;
        t_result res1;
    } t_push;

    function automatic logic [31:0] crc32c_byte(logic [31:0] crc, logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[hw/rtl/cdcc_parser.sv]
// Frame parser: header capture, payload CRC and summary generation for one byte per cycle while i_adv is high.
module cdcc_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic [7:0]          i_byte,
    input  logic                i_end,
    output cdcc_pkg::t_push     o_push
);

    cdcc_pkg::t_phase                r_phase, n_phase;
    logic [cdcc_pkg::POS_W-1:0]      r_pos, n_pos;
    logic [31:0]                     r_index, n_index;
    logic [31:0]                     r_length, n_length;
    logic [31:0]                     r_stored, n_stored;
    logic [7:0]                      r_flags, n_flags;
    logic                            r_rsvd_bad, n_rsvd_bad;
    logic [cdcc_pkg::LEFT_W-1:0]     r_left, n_left;
    logic [31:0]                     r_crc, n_crc;

    logic            do_clear;
    logic            go_payload;
    logic            go_done;
    logic            hdr_last;
    logic [4:0]      lane_lo;
    logic [31:0]     crc_new;
    logic [cdcc_pkg::LEFT_W-1:0] left_dec;

    function automatic cdcc_pkg::t_result mk_summary(
        logic [31:0] idx, logic [31:0] len, logic [7:0] flg,
        logic [1:0] st, logic match);
        cdcc_pkg::t_result r;
        r.kind         = cdcc_pkg::KIND_SUMMARY;
        r.payload_byte = 8'd0;
        r.frame_seq    = idx;
        r.payload_len  = len;
        r.chunk_flags  = flg;
        r.status       = st;
        r.crc_match    = (st == cdcc_pkg::ST_OK) ? match : 1'b0;
        return r;
    endfunction

    // Datapath and result selection.
    always_comb begin
        n_pos      = r_pos;
        n_index    = r_index;
        n_length   = r_length;
        n_stored   = r_stored;
        n_flags    = r_flags;
        n_rsvd_bad = r_rsvd_bad;
        n_left     = r_left;
        n_crc      = r_crc;
        do_clear   = 1'b0;
        go_payload = 1'b0;
        go_done    = 1'b0;
        o_push     = '0;

        // Big-endian byte lane inside a 32-bit header word.
        lane_lo  = {~r_pos[1:0], 3'b000};
        hdr_last = (r_pos == cdcc_pkg::POS_LAST);
        crc_new  = cdcc_pkg::crc32c_byte(r_crc, i_byte);
        left_dec = (r_left != '0) ? (r_left - cdcc_pkg::LEFT_W'(1)) : '0;

        unique case (r_phase)
            cdcc_pkg::PH_HEADER: begin
                if (r_pos < cdcc_pkg::POS_LEN) begin
                    n_index[lane_lo +: 8] = r_index[lane_lo +: 8] | i_byte;
                end else if (r_pos < cdcc_pkg::POS_CRC) begin
                    n_length[lane_lo +: 8] = r_length[lane_lo +: 8] | i_byte;
                end else if (r_pos < cdcc_pkg::POS_FLAGS) begin
                    n_stored[lane_lo +: 8] = r_stored[lane_lo +: 8] | i_byte;
                end else if (r_pos == cdcc_pkg::POS_FLAGS) begin
                    n_flags = i_byte;
                end else if (i_byte != 8'd0) begin
                    n_rsvd_bad = 1'b1;
                end

                if (!hdr_last) begin
                    n_pos = r_pos + cdcc_pkg::POS_W'(1);
                    if (i_end) begin
                        o_push.vld0 = 1'b1;
                        o_push.res0 = mk_summary(n_index, n_length, n_flags,
                                                 cdcc_pkg::ST_TRUNC, 1'b0);
                        do_clear    = 1'b1;
                    end
                end else begin
                    o_push.vld0 = 1'b1;
                    if (n_rsvd_bad) begin
                        o_push.res0 = mk_summary(n_index, n_length, n_flags,
                                                 cdcc_pkg::ST_RSVD, 1'b0);
                    end else if (n_length > 32'(cdcc_pkg::MAX_CHUNK_BYTES)) begin
                        o_push.res0 = mk_summary(n_index, n_length, n_flags,
                                                 cdcc_pkg::ST_LONG, 1'b0);
                    end else if (n_length == 32'd0) begin
                        o_push.res0 = mk_summary(n_index, n_length, n_flags,
                                                 cdcc_pkg::ST_OK, n_stored == 32'd0);
                    end else if (i_end) begin
                        o_push.res0 = mk_summary(n_index, n_length, n_flags,
                                                 cdcc_pkg::ST_TRUNC, 1'b0);
                    end else begin
                        o_push.vld0 = 1'b0;
                        go_payload  = 1'b1;
                        n_left      = n_length[cdcc_pkg::LEFT_W-1:0];
                        n_crc       = cdcc_pkg::CRC_INIT;
                    end
                    if (o_push.vld0) begin
                        do_clear = i_end;
                        go_done  = !i_end;
                    end
                end
            end
            cdcc_pkg::PH_PAYLOAD: begin
                o_push.vld0              = 1'b1;
                o_push.res0              = '0;
                o_push.res0.kind         = cdcc_pkg::KIND_PAYLOAD;
                o_push.res0.payload_byte = i_byte;
                n_crc                    = crc_new;
                n_left                   = left_dec;
                if (left_dec == '0) begin
                    o_push.vld1 = 1'b1;
                    o_push.res1 = mk_summary(r_index, r_length, r_flags, cdcc_pkg::ST_OK,
                                             (crc_new ^ cdcc_pkg::CRC_INIT) == r_stored);
                    do_clear    = i_end;
                    go_done     = !i_end;
                end else if (i_end) begin
                    o_push.vld1 = 1'b1;
                    o_push.res1 = mk_summary(r_index, r_length, r_flags,
                                             cdcc_pkg::ST_TRUNC, 1'b0);
                    do_clear    = 1'b1;
                end
            end
            cdcc_pkg::PH_DONE: begin
                do_clear = i_end;
            end
            default: begin
                do_clear = i_end;
                go_done  = !i_end;
            end
        endcase
    end

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (do_clear) begin
            n_phase = cdcc_pkg::PH_HEADER;
        end else if (go_payload) begin
            n_phase = cdcc_pkg::PH_PAYLOAD;
        end else if (go_done) begin
            n_phase = cdcc_pkg::PH_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_adv && do_clear)) begin
            r_phase    <= cdcc_pkg::PH_HEADER;
            r_pos      <= '0;
            r_index    <= '0;
            r_length   <= '0;
            r_stored   <= '0;
            r_flags    <= '0;
            r_rsvd_bad <= 1'b0;
            r_left     <= '0;
            r_crc      <= cdcc_pkg::CRC_INIT;
        end else if (i_adv) begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_index    <= n_index;
            r_length   <= n_length;
            r_stored   <= n_stored;
            r_flags    <= n_flags;
            r_rsvd_bad <= n_rsvd_bad;
            r_left     <= n_left;
            r_crc      <= n_crc;
        end
    end

endmodule

[hw/rtl/cdcc_res_fifo.sv]
// Result queue: takes up to two results per cycle and delivers one per cycle while the reader pops.
module cdcc_res_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  cdcc_pkg::t_push     i_push,
    output logic                o_space_ok,
    output logic                o_valid,
    input  logic                i_pop,
    output cdcc_pkg::t_result   o_head
);

    cdcc_pkg::t_result                 r_mem [cdcc_pkg::FIFO_DEPTH];
    logic [cdcc_pkg::FIFO_AW-1:0]      r_wp, n_wp;
    logic [cdcc_pkg::FIFO_AW-1:0]      r_rp, n_rp;
    logic [cdcc_pkg::FIFO_CW-1:0]      r_cnt, n_cnt;
    logic [cdcc_pkg::FIFO_AW-1:0]      wp1;
    logic                              wr0, wr1, pop;

    assign wp1        = r_wp + cdcc_pkg::FIFO_AW'(1);
    assign wr0        = i_wr && i_push.vld0;
    assign wr1        = i_wr && i_push.vld1;
    assign o_valid    = (r_cnt != '0);
    assign pop        = o_valid && i_pop;
    assign o_space_ok = (r_cnt <= cdcc_pkg::FIFO_CW'(cdcc_pkg::FIFO_DEPTH - 2));
    assign o_head     = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp + cdcc_pkg::FIFO_AW'(wr0) + cdcc_pkg::FIFO_AW'(wr1);
        n_rp  = r_rp + cdcc_pkg::FIFO_AW'(pop);
        n_cnt = r_cnt + cdcc_pkg::FIFO_CW'(wr0) + cdcc_pkg::FIFO_CW'(wr1)
              - cdcc_pkg::FIFO_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr0) begin
            r_mem[r_wp] <= i_push.res0;
        end
        if (wr1) begin
            r_mem[wp1] <= i_push.res1;
        end
    end

endmodule

[hw/rtl/chunk_deframer_crc_check.sv]
// Top level of the chunk deframer with CRC-32C check: input register, parser, result queue.
// An accepted byte is held in the input register and parsed from it; its results are written
// into the result queue, whose head drives the output ports. Throughput: one byte per cycle
// while the queue has room for two results; a byte that ends a payload gives two results, which
// the four-entry queue drains one per cycle while the receiver is ready. Reset is synchronous,
// active low, and clears the parser state, input register and queue; no clearing pass is needed.
module chunk_deframer_crc_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input byte channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_buffer_end,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic [7:0]  o_payload_byte,
    output logic [31:0] o_frame_seq,
    output logic [31:0] o_payload_len,
    output logic [7:0]  o_chunk_flags,
    output logic [1:0]  o_status,
    output logic        o_crc_match
);

    // The input register holds one accepted item until the parser can consume it.
    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_end;

    logic                space_ok;
    logic                adv;
    cdcc_pkg::t_push     push;
    cdcc_pkg::t_result   head;

    // The parser consumes the held item only when the queue has room for two results,
    // so a payload-ending byte can never overflow it. The input side stalls only while
    // more than two results wait in the queue.
    assign adv        = r_in_vld && space_ok;
    assign o_in_ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_end  <= i_buffer_end;
        end
    end

    cdcc_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_byte  (r_in_byte),
        .i_end   (r_in_end),
        .o_push  (push)
    );

    cdcc_res_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (adv),
        .i_push     (push),
        .o_space_ok (space_ok),
        .o_valid    (o_out_valid),
        .i_pop      (i_out_ready),
        .o_head     (head)
    );

    // The head of the queue drives the result ports directly.
    assign o_kind         = head.kind;
    assign o_payload_byte = head.payload_byte;
    assign o_frame_seq    = head.frame_seq;
    assign o_payload_len  = head.payload_len;
    assign o_chunk_flags  = head.chunk_flags;
    assign o_status       = head.status;
    assign o_crc_match    = head.crc_match;

endmodule

[hw/rtl/cdcc_checker.sv]
// Port-level checker for the chunk deframer, bound to the top level.
`include "chunk_deframer_crc_check_defines.svh"

module cdcc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [7:0]  i_data_byte,
    input logic        i_buffer_end,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_kind,
    input logic [7:0]  o_payload_byte,
    input logic [31:0] o_frame_seq,
    input logic [31:0] o_payload_len,
    input logic [7:0]  o_chunk_flags,
    input logic [1:0]  o_status,
    input logic        o_crc_match
);

    logic         stalled;
    logic [11:0]  held;
    logic         match_seen;
    logic         ok_summary;
    logic         pay_seen;
    logic         pay_clean;
    logic         sum_seen;
    logic         sum_clean;

    // A stalled item keeps valid high along with its payload.
    assign stalled    = o_out_valid && !i_out_ready;
    assign held       = {o_out_valid, o_kind, o_payload_byte, o_status};
    assign match_seen = o_out_valid && o_crc_match;
    assign ok_summary = o_kind && (o_status == cdcc_pkg::ST_OK);
    assign pay_seen   = o_out_valid && !o_kind;
    assign pay_clean  = (o_status == cdcc_pkg::ST_OK) && (o_frame_seq == 32'd0)
                     && (o_payload_len == 32'd0) && (o_chunk_flags == 8'd0) && !o_crc_match;
    assign sum_seen   = o_out_valid && o_kind;
    assign sum_clean  = (o_payload_byte == 8'd0);

    `CDCC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, stalled, $stable(held), "stalled result changed")
    `CDCC_ASSERT_IMP(a_match_ok, i_clk, i_rst_n, match_seen, ok_summary, "stray crc match")
    `CDCC_ASSERT_IMP(a_payload_clean, i_clk, i_rst_n, pay_seen, pay_clean, "dirty payload item")
    `CDCC_ASSERT_IMP(a_summary_clean, i_clk, i_rst_n, sum_seen, sum_clean, "dirty summary item")

endmodule

bind chunk_deframer_crc_check cdcc_checker u_cdcc_checker (.*);

[tb/tb.sv]
// Self-checking testbench for the chunk deframer with CRC-32C check.
`timescale 1ns / 100ps

module tb;
    import cdcc_pkg::*;

    // Longest run that still counts as alive; real runs need a small fraction.
    localparam int CYCLE_LIMIT = 400000;
    // Input items wanted over the whole run.
    localparam int TOTAL_BYTES = 1750;
    // Cycles to watch the output after the last expected result.
    localparam int SETTLE_CYCLES = 16;

    // Scoreboard: keeps a copy of the parser state, predicts the results of
    // each accepted byte and checks the block's results against them in order.
    class deframe_scoreboard;
        t_result     due_results[$];
        int          mismatches;

        t_phase      phase;
        logic [4:0]  hdr_pos;
        logic [31:0] chunk_idx;
        logic [31:0] chunk_len;
        logic [31:0] crc_stored;
        logic [7:0]  flags;
        bit          rsvd_bad;
        logic [16:0] left;
        logic [31:0] crc_run;

        function new();
            mismatches = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            phase      = PH_HEADER;
            hdr_pos    = '0;
            chunk_idx  = '0;
            chunk_len  = '0;
            crc_stored = '0;
            flags      = '0;
            rsvd_bad   = 1'b0;
            left       = '0;
            crc_run    = CRC_INIT;
        endfunction

        // One byte of reflected CRC-32C, taken one data bit at a time.
        static function logic [31:0] crc_update(logic [31:0] c, logic [7:0] b);
            logic [31:0] r;
            logic        fb;
            r = c;
            for (int i = 0; i < 8; i++) begin
                fb = r[0] ^ b[i];
                r  = r >> 1;
                if (fb) begin
                    r = r ^ CRC_POLY;
                end
            end
            return r;
        endfunction

        function void push_summary(logic [1:0] st, bit match);
            t_result r;
            r             = '0;
            r.kind        = KIND_SUMMARY;
            r.frame_seq   = chunk_idx;
            r.payload_len = chunk_len;
            r.chunk_flags = flags;
            r.status      = st;
            r.crc_match   = (st == ST_OK) ? match : 1'b0;
            due_results.push_back(r);
        endfunction

        // After a summary the frame either restarts at once or waits for
        // the end of the buffer.
        function void close_frame(logic last);
            if (last) begin
                clear_frame();
            end else begin
                phase = PH_DONE;
            end
        endfunction

        // Notes one accepted byte and queues the results it causes.
        function void take_byte(logic [7:0] b, logic last);
            t_result r;
            int      p;
            if (phase == PH_HEADER) begin
                p = int'(hdr_pos);
                if (p < 4) begin
                    chunk_idx[8*(3-p) +: 8] = b;
                end else if (p < 8) begin
                    chunk_len[8*(7-p) +: 8] = b;
                end else if (p < 12) begin
                    crc_stored[8*(11-p) +: 8] = b;
                end else if (p == 12) begin
                    flags = b;
                end else if (b != 8'd0) begin
                    rsvd_bad = 1'b1;
                end
                if (p + 1 < HEADER_BYTES) begin
                    hdr_pos = hdr_pos + 5'd1;
                    if (last) begin
                        push_summary(ST_TRUNC, 1'b0);
                        clear_frame();
                    end
                    return;
                end
                hdr_pos = 5'(HEADER_BYTES);
                // Reserved bytes win over the length limit, which wins over
                // the empty-payload shortcut.
                if (rsvd_bad) begin
                    push_summary(ST_RSVD, 1'b0);
                end else if (chunk_len > 32'(MAX_CHUNK_BYTES)) begin
                    push_summary(ST_LONG, 1'b0);
                end else if (chunk_len == 32'd0) begin
                    push_summary(ST_OK, crc_stored == 32'd0);
                end else if (last) begin
                    push_summary(ST_TRUNC, 1'b0);
                end else begin
                    phase   = PH_PAYLOAD;
                    left    = chunk_len[16:0];
                    crc_run = CRC_INIT;
                    return;
                end
                close_frame(last);
                return;
            end
            if (phase == PH_PAYLOAD) begin
                r              = '0;
                r.kind         = KIND_PAYLOAD;
                r.payload_byte = b;
                due_results.push_back(r);
                crc_run = crc_update(crc_run, b);
                if (left != '0) begin
                    left = left - 17'd1;
                end
                if (left == '0) begin
                    push_summary(ST_OK, (crc_run ^ CRC_INIT) == crc_stored);
                    close_frame(last);
                end else if (last) begin
                    push_summary(ST_TRUNC, 1'b0);
                    clear_frame();
                end
                return;
            end
            close_frame(last);
        endfunction

        task report_mismatch(string what, logic [31:0] seen, logic [31:0] want);
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, seen,
                want);
            mismatches++;
        endtask

        task check_result(t_result seen);
            t_result want;
            if (due_results.size() == 0) begin
                report_mismatch("unexpected result kind", 32'(seen.kind), 32'd0);
                return;
            end
            want = due_results.pop_front();
            if (seen.kind !== want.kind)
                report_mismatch("kind", 32'(seen.kind), 32'(want.kind));
            if (seen.payload_byte !== want.payload_byte)
                report_mismatch("payload_byte", 32'(seen.payload_byte), 32'(want.payload_byte));
            if (seen.frame_seq !== want.frame_seq)
                report_mismatch("frame_seq", seen.frame_seq, want.frame_seq);
            if (seen.payload_len !== want.payload_len)
                report_mismatch("payload_len", seen.payload_len, want.payload_len);
            if (seen.chunk_flags !== want.chunk_flags)
                report_mismatch("chunk_flags", 32'(seen.chunk_flags), 32'(want.chunk_flags));
            if (seen.status !== want.status)
                report_mismatch("status", 32'(seen.status), 32'(want.status));
            if (seen.crc_match !== want.crc_match)
                report_mismatch("crc_match", 32'(seen.crc_match), 32'(want.crc_match));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_buffer_end;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_kind;
    logic [7:0]  o_payload_byte;
    logic [31:0] o_frame_seq;
    logic [31:0] o_payload_len;
    logic [7:0]  o_chunk_flags;
    logic [1:0]  o_status;
    logic        o_crc_match;

    deframe_scoreboard sb;

    int cycle_cnt;
    int burst_left;
    int sent_bytes;
    int frames_sent;

    // Receiver stall pattern state.
    int stall_mode;
    int mode_left;
    int stall_left;

    chunk_deframer_crc_check i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_buffer_end   (i_buffer_end),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_payload_byte (o_payload_byte),
        .o_frame_seq    (o_frame_seq),
        .o_payload_len  (o_payload_len),
        .o_chunk_flags  (o_chunk_flags),
        .o_status       (o_status),
        .o_crc_match    (o_crc_match)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("chunk_deframer_crc_check regression: fail");
            $finish;
        end
    end

    // Result side: check every accepted result, then choose the next ready.
    // The stall pattern switches between always ready, coin-flip, mostly
    // stalled and occasional long stalls, each held for a random stretch.
    always @(posedge i_clk) begin : result_sink
        t_result seen;
        logic    rdy;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen.kind         = o_kind;
            seen.payload_byte = o_payload_byte;
            seen.frame_seq    = o_frame_seq;
            seen.payload_len  = o_payload_len;
            seen.chunk_flags  = o_chunk_flags;
            seen.status       = o_status;
            seen.crc_match    = o_crc_match;
            sb.check_result(seen);
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
        end
        mode_left--;
        case (stall_mode)
            0: begin
                rdy = 1'b1;
            end
            1: begin
                rdy = 1'($urandom_range(0, 1));
            end
            2: begin
                rdy = ($urandom_range(0, 3) == 0);
            end
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    rdy = 1'b0;
                end else begin
                    rdy = 1'b1;
                    if ($urandom_range(0, 7) == 0) begin
                        stall_left = $urandom_range(1, 24);
                    end
                end
            end
        endcase
        i_out_ready <= rdy;
    end

    // Offers one byte and waits until it is accepted. Bytes go out in bursts;
    // a finished burst is followed by a random gap with valid low.
    task automatic push_byte(input logic [7:0] b, input logic last);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 48);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= b;
        i_buffer_end <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.take_byte(b, last);
        sent_bytes++;
        burst_left--;
    endtask

    // Holds the sender until every predicted result has come out.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (sb.due_results.size() != 0);
    endtask

    // Sends one buffer: a header, pay_cnt payload bytes and trail extra bytes.
    // A hdr_cut below the header size ends the buffer on that header byte.
    // Without fix_crc the stored CRC is the true CRC of the payload sent.
    task automatic send_frame(input logic [31:0] idx, input logic [31:0] len,
                              input bit fix_crc, input logic [31:0] crc_val,
                              input logic [7:0] flg, input logic [23:0] rsvd,
                              input int pay_cnt, input int trail, input int hdr_cut);
        logic [7:0]   pay_q[$];
        logic [7:0]   buf_q[$];
        logic [31:0]  crc;
        logic [127:0] hdr_word;
        crc = CRC_INIT;
        for (int i = 0; i < pay_cnt; i++) begin
            pay_q.push_back(8'($urandom));
            crc = deframe_scoreboard::crc_update(crc, pay_q[i]);
        end
        crc      = fix_crc ? crc_val : (crc ^ CRC_INIT);
        hdr_word = {idx, len, crc, flg, rsvd};
        for (int k = 0; k < HEADER_BYTES && k <= hdr_cut; k++) begin
            buf_q.push_back(hdr_word[127 - 8*k -: 8]);
        end
        if (hdr_cut >= HEADER_BYTES) begin
            foreach (pay_q[i]) buf_q.push_back(pay_q[i]);
            repeat (trail) buf_q.push_back(8'($urandom));
        end
        foreach (buf_q[i]) begin
            push_byte(buf_q[i], i == buf_q.size() - 1);
        end
        frames_sent++;
    endtask

    // One random buffer. Most are well-formed frames with random content;
    // the rest are cut short, carry bad reserved bytes or huge lengths, or
    // are plain noise.
    task automatic send_random_frame();
        int          pick;
        int          n;
        logic [31:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            n = $urandom_range(0, 99);
            if (n < 10) len = 0;
            else if (n < 15) len = $urandom_range(25, 300);
            else len = $urandom_range(1, 24);
            send_frame($urandom, len, $urandom_range(0, 6) == 0, $urandom, 8'($urandom),
                       24'd0, int'(len),
                       ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0,
                       HEADER_BYTES);
        end else if (pick < 70) begin
            len = $urandom_range(2, 30);
            send_frame($urandom, len, 1'b0, 32'd0, 8'($urandom), 24'd0,
                       $urandom_range(0, len - 1), 0, HEADER_BYTES);
        end else if (pick < 80) begin
            send_frame($urandom, $urandom, 1'b1, $urandom, 8'($urandom), 24'($urandom),
                       0, 0, $urandom_range(0, HEADER_BYTES - 2));
        end else if (pick < 88) begin
            // Reserved bytes nonzero: everything after the header is ignored.
            send_frame($urandom, $urandom_range(0, 20), 1'b1, $urandom, 8'($urandom),
                       24'($urandom_range(1, 24'hFF_FFFF)), 0, $urandom_range(0, 3),
                       HEADER_BYTES);
        end else if (pick < 96) begin
            len = ($urandom_range(0, 3) == 0) ? 32'(MAX_CHUNK_BYTES + 1)
                : 32'($urandom_range(MAX_CHUNK_BYTES + 1, 32'hFFFF_FFFF));
            send_frame($urandom, len, 1'b1, $urandom, 8'($urandom), 24'd0, 0,
                       $urandom_range(0, 3), HEADER_BYTES);
        end else begin
            n = $urandom_range(1, 40);
            for (int i = 0; i < n; i++) begin
                push_byte(8'($urandom), i == n - 1);
            end
            frames_sent++;
        end
    endtask

    initial begin
        sb           = new();
        cycle_cnt    = 0;
        burst_left   = 0;
        sent_bytes   = 0;
        frames_sent  = 0;
        stall_mode   = 0;
        mode_left    = 0;
        stall_left   = 0;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_data_byte  <= 8'd0;
        i_buffer_end <= 1'b0;
        i_out_ready  <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames.
        // Good one-byte payload with all-ones index and flags, ending on it.
        send_frame(32'hFFFF_FFFF, 32'd1, 1'b0, 32'd0, 8'hFF, 24'd0, 1, 0, HEADER_BYTES);
        // Wrong stored CRC, then trailing bytes up to the buffer end.
        send_frame(32'd0, 32'd3, 1'b1, 32'hDEAD_BEEF, 8'h00, 24'd0, 3, 2, HEADER_BYTES);
        // Empty payloads: a zero stored CRC matches, any other does not.
        send_frame(32'h1234_5678, 32'd0, 1'b1, 32'd0, 8'h5A, 24'd0, 0, 0, HEADER_BYTES);
        send_frame(32'h8000_0001, 32'd0, 1'b1, 32'd1, 8'hA5, 24'd0, 0, 1, HEADER_BYTES);
        // Reserved bytes nonzero in the top and the bottom bit.
        send_frame(32'd1, 32'd5, 1'b0, 32'd0, 8'h01, 24'h80_0000, 4, 0, HEADER_BYTES);
        send_frame(32'd2, 32'd0, 1'b1, 32'd0, 8'h80, 24'h00_0001, 0, 0, HEADER_BYTES);
        // Just over the length limit, and the largest length there is.
        send_frame(32'd3, 32'(MAX_CHUNK_BYTES + 1), 1'b1, 32'd0, 8'd0, 24'd0, 0, 1,
                   HEADER_BYTES);
        send_frame(32'd4, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 8'd0, 24'd0, 0, 0,
                   HEADER_BYTES);
        // Reserved bytes and length both bad: the reserved check wins.
        send_frame(32'd5, 32'h0002_0000, 1'b1, 32'd0, 8'd0, 24'h00_0100, 0, 0,
                   HEADER_BYTES);
        // Length exactly at the limit, buffer ends after three payload bytes.
        send_frame(32'd6, 32'(MAX_CHUNK_BYTES), 1'b1, 32'd0, 8'd0, 24'd0, 3, 0,
                   HEADER_BYTES);
        // Header cut after the first byte and right before the last one.
        send_frame(32'hAB00_0000, 32'd9, 1'b1, 32'd0, 8'd0, 24'd0, 0, 0, 0);
        send_frame(32'h0102_0304, 32'd9, 1'b1, 32'h0506_0708, 8'h09, 24'd0, 0, 0,
                   HEADER_BYTES - 2);
        // Buffer ends on the last header byte with a payload still owed.
        send_frame(32'd7, 32'd7, 1'b0, 32'd0, 8'd0, 24'd0, 0, 0, HEADER_BYTES);
        drain_results();

        // Random part, until the whole run has sent about the wanted items.
        while (sent_bytes < TOTAL_BYTES) begin
            send_random_frame();
            if (frames_sent % 25 == 0) begin
                drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("chunk_deframer_crc_check regression: pass");
        end else begin
            $display("chunk_deframer_crc_check regression: fail");
        end
        $finish;
    end

endmodule
